// ===== rtl/mvsm_pkg.sv =====
// shared types and constants of the multi-voice sample mixer
// command codes, sequencer states, voice record, serial unit status
// no dependencies
package mvsm_pkg;

	// command codes carried in s_tuser
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_START = 2'd1,
		CMD_GAIN  = 2'd2,
		CMD_MIX   = 2'd3
	} mvsm_cmd_t;

	// gain constants, unsigned Q2.14
	localparam logic [15:0] UNITY_GAIN = 16'd16384;

	// stream word widths
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 40;

	// serial unit widths
	localparam int MUL_MC_W  = 32;
	localparam int MUL_MP_W  = 18;
	localparam int DIV_NUM_W = 31;
	localparam int DIV_DEN_W = 25;

	// handshake of a serial unit back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} mvsm_unit_stat_t;

	// one input word unpacked
	typedef struct packed {
		logic [15:0] address;
		logic [15:0] sample_data;
		logic [15:0] sound_base;
		logic [16:0] sound_length;
		logic        loop_flag;
		logic [15:0] tweak_gain;
		logic [4:0]  voice_select;
		logic [15:0] user_gain;
	} mvsm_item_t;

	// per-voice record held in the voice memory
	typedef struct packed {
		logic               loops;
		logic [15:0]        base;
		logic [16:0]        len;
		logic [16:0]        pos;
		logic [15:0]        tweak;
		logic [15:0]        user;
		logic [17:0]        prev;
		logic [17:0]        origin;
		logic signed [31:0] slope;
	} mvsm_voice_t;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_WADDR,
		S_WADDR_W,
		S_SCAN,
		S_SET,
		S_SET_W,
		S_MIX_VOICE,
		S_MIX_LOAD,
		S_G1,
		S_G1_W,
		S_G2,
		S_G2_W,
		S_START_WR,
		S_RAMP,
		S_RAMP_W,
		S_CUR,
		S_CUR_W,
		S_ADDR,
		S_ADDR_W,
		S_RD,
		S_RD_W,
		S_WMUL_W,
		S_VOICE_WR,
		S_FINISH
	} mvsm_state_t;

endpackage

// ===== rtl/multi_voice_sample_mixer.sv =====
// top level of the multi-voice sample mixer: command sequencer, voice state,
// sample memory; uses mvsm_pkg, mvsm_ram, mvsm_serial_mul, mvsm_serial_div
//
// channel   dir  signals                     word
// s_*       in   s_tvalid s_tready s_tdata   one command (s_tuser = command)
// m_*       out  m_tvalid m_tready m_tdata   one result (m_tuser = status)
// cfg_*     in   cfg_valid cfg_ready         master gain write
//
// each command runs to completion on the sequencer before the next is taken;
// multiplies go through a shift-add unit, divisions and address wrap
// (when SAMPLE_WORDS is not a power of two) through a restoring divider.
// reset clears voice active bits and frame count and sets master gain to
// unity. a result waiting on m_tready holds the block only when a second
// one is done.
module multi_voice_sample_mixer import mvsm_pkg::*; #(
	parameter int NUM_VOICES     = 32,
	parameter int SAMPLE_WORDS   = 65536,
	parameter int BUFFER_SAMPLES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// address, sample_data, sound_base, sound_length, loop_flag,
	// tweak_gain, voice_select, user_gain, one zero bit
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// left_sample, right_sample, voice_index, three zero bits
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [0:0]            m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data
);

	localparam int AW      = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
	localparam bit SW_POW2 = ((SAMPLE_WORDS & (SAMPLE_WORDS - 1)) == 0);
	localparam int VW      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int VC      = $clog2(NUM_VOICES + 1);
	localparam int FRAMES  = BUFFER_SAMPLES / 2;
	localparam int FW      = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	mvsm_state_t        state_q, state_d;
	mvsm_cmd_t          cmd_q;
	mvsm_item_t         item_q, item_in;
	logic [VC-1:0]      v_q, v_d;
	logic               k_q, k_d;
	mvsm_voice_t        rec_q, rec_d;
	logic [17:0]        g_q, g_d;
	logic [17:0]        cur_q, cur_d;
	logic [AW-1:0]      addr_q, addr_d;
	logic signed [31:0] acc_l_q, acc_l_d, acc_r_q, acc_r_d;
	logic [FW-1:0]      frame_q, frame_d;
	logic [NUM_VOICES-1:0] active_q, active_d;
	logic [15:0]        res_l_q, res_l_d, res_r_q, res_r_d;
	logic [4:0]         res_vidx_q, res_vidx_d;
	logic               res_stat_q, res_stat_d;
	logic               out_valid_q, out_load;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic               out_user_q;
	logic [15:0]        master_q;
	logic               accept;

	// serial units
	logic                         mul_start;
	logic signed [MUL_MC_W-1:0]   mul_mc;
	logic [MUL_MP_W-1:0]          mul_mp;
	mvsm_unit_stat_t              mul_stat;
	logic signed [MUL_MC_W+MUL_MP_W-1:0] mul_prod;
	logic                         div_start;
	logic [DIV_NUM_W-1:0]         div_num;
	logic [DIV_DEN_W-1:0]         div_den;
	mvsm_unit_stat_t              div_stat;
	logic [DIV_NUM_W-1:0]         div_quot;
	logic [DIV_DEN_W-1:0]         div_rem;

	// memories
	logic               samp_we, samp_re;
	logic [AW-1:0]      samp_waddr, samp_raddr;
	logic [15:0]        samp_rdata;
	logic               vr_we, vr_re;
	logic [VW-1:0]      vr_waddr, vr_raddr;
	mvsm_voice_t        vr_wdata, vr_rdata;

	// derived values
	logic [VW-1:0]      v_idx;
	logic               v_done;
	logic [VW+4:0]      sel_wide;
	logic [VW-1:0]      sel_idx;
	logic               sel_ok;
	logic [VC+4:0]      v_wide;
	logic [15:0]        user_src, user_min, tweak_src;
	logic [FW+18:0]     j_wide;
	logic [17:0]        posk, sum_addr;
	logic               silent;
	logic [AW+17:0]     sum_wide;
	logic [AW+15:0]     waddr_wide;
	logic signed [18:0] gdiff;
	logic [18:0]        gmag;
	logic signed [31:0] quot_s;
	logic signed [50:0] ramp_t;
	logic signed [49:0] contrib_adj, contrib_sh;
	logic signed [31:0] contrib;
	logic [17:0]        newpos;
	logic               wrap;
	mvsm_voice_t        rec_wr;

	function automatic logic [15:0] sat16(input logic signed [31:0] x);
		if (x > 32'sd32767) begin
			return 16'h7fff;
		end else if (x < -32'sd32768) begin
			return 16'h8000;
		end
		return x[15:0];
	endfunction

	// unpack the input word
	always_comb begin
		item_in.address      = s_tdata[15:0];
		item_in.sample_data  = s_tdata[31:16];
		item_in.sound_base   = s_tdata[47:32];
		item_in.sound_length = s_tdata[64:48];
		item_in.loop_flag    = s_tdata[65];
		item_in.tweak_gain   = s_tdata[81:66];
		item_in.voice_select = s_tdata[86:82];
		item_in.user_gain    = s_tdata[102:87];
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// voice indexing
	assign v_idx    = v_q[VW-1:0];
	assign v_done   = (v_q == VC'(NUM_VOICES));
	assign sel_wide = {{VW{1'b0}}, item_q.voice_select};
	assign sel_idx  = sel_wide[VW-1:0];
	assign sel_ok   = sel_wide < (VW+5)'(NUM_VOICES);
	assign v_wide   = {5'b0, v_q};

	// gain operands
	assign user_src  = (cmd_q == CMD_START) ? UNITY_GAIN : rec_q.user;
	assign user_min  = (user_src > UNITY_GAIN) ? UNITY_GAIN : user_src;
	assign tweak_src = (cmd_q == CMD_START) ? item_q.tweak_gain : rec_q.tweak;
	assign j_wide    = {18'b0, frame_q, 1'b0};

	// sample address of the current word
	assign posk       = {1'b0, rec_q.pos} + {17'b0, k_q};
	assign silent     = posk >= {1'b0, rec_q.len};
	assign sum_addr   = {2'b0, rec_q.base} + posk;
	assign sum_wide   = {{AW{1'b0}}, sum_addr};
	assign waddr_wide = {{AW{1'b0}}, item_q.address};

	// ramp slope from the gain step
	assign gdiff  = $signed({1'b0, g_q}) - $signed({1'b0, rec_q.prev});
	assign gmag   = gdiff[18] ? 19'(-gdiff) : 19'(gdiff);
	assign quot_s = $signed({1'b0, div_quot});

	// ramped gain and word contribution
	assign ramp_t      = $signed({21'b0, rec_q.origin, 12'b0})
		+ $signed({mul_prod[49], mul_prod});
	assign contrib_adj = mul_prod[49] ? (mul_prod + 50'sd16383) : mul_prod;
	assign contrib_sh  = contrib_adj >>> 14;
	assign contrib     = contrib_sh[31:0];

	// position advance at the end of a voice
	assign newpos = {1'b0, rec_q.pos} + 18'd2;
	assign wrap   = ({1'b0, newpos} + 19'd1) >= {2'b0, rec_q.len};
	always_comb begin
		rec_wr     = rec_q;
		rec_wr.pos = (wrap && rec_q.loops) ? 17'd0 : newpos[16:0];
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			active_q <= '0;
			frame_q  <= '0;
			v_q      <= '0;
			k_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			active_q <= active_d;
			frame_q  <= frame_d;
			v_q      <= v_d;
			k_q      <= k_d;
		end
	end

	// sequencer payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_in;
			cmd_q  <= mvsm_cmd_t'(s_tuser);
		end
		rec_q      <= rec_d;
		g_q        <= g_d;
		cur_q      <= cur_d;
		addr_q     <= addr_d;
		acc_l_q    <= acc_l_d;
		acc_r_q    <= acc_r_d;
		res_l_q    <= res_l_d;
		res_r_q    <= res_r_d;
		res_vidx_q <= res_vidx_d;
		res_stat_q <= res_stat_d;
	end

	// next state and datapath control
	always_comb begin
		state_d    = state_q;
		v_d        = v_q;
		k_d        = k_q;
		rec_d      = rec_q;
		g_d        = g_q;
		cur_d      = cur_q;
		addr_d     = addr_q;
		acc_l_d    = acc_l_q;
		acc_r_d    = acc_r_q;
		frame_d    = frame_q;
		active_d   = active_q;
		res_l_d    = res_l_q;
		res_r_d    = res_r_q;
		res_vidx_d = res_vidx_q;
		res_stat_d = res_stat_q;
		out_load   = 1'b0;
		mul_start  = 1'b0;
		mul_mc     = '0;
		mul_mp     = '0;
		div_start  = 1'b0;
		div_num    = '0;
		div_den    = '0;
		samp_we    = 1'b0;
		samp_waddr = waddr_wide[AW-1:0];
		samp_re    = 1'b0;
		samp_raddr = addr_q;
		vr_we      = 1'b0;
		vr_waddr   = v_idx;
		vr_wdata   = rec_wr;
		vr_re      = 1'b0;
		vr_raddr   = v_idx;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					v_d        = '0;
					acc_l_d    = '0;
					acc_r_d    = '0;
					res_l_d    = '0;
					res_r_d    = '0;
					res_vidx_d = '0;
					res_stat_d = 1'b0;
					unique case (mvsm_cmd_t'(s_tuser))
						CMD_WRITE: state_d = S_WADDR;
						CMD_START: state_d = S_SCAN;
						CMD_GAIN:  state_d = S_SET;
						CMD_MIX:   state_d = S_MIX_VOICE;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			// sample write, address wrapped to the memory size
			S_WADDR: begin
				if (SW_POW2) begin
					samp_we = 1'b1;
					state_d = S_FINISH;
				end else begin
					div_start = 1'b1;
					div_num   = {15'b0, item_q.address};
					div_den   = DIV_DEN_W'(SAMPLE_WORDS);
					state_d   = S_WADDR_W;
				end
			end
			S_WADDR_W: begin
				samp_waddr = div_rem[AW-1:0];
				if (div_stat.done) begin
					samp_we = 1'b1;
					state_d = S_FINISH;
				end
			end
			// lowest free voice search
			S_SCAN: begin
				if (v_done) begin
					res_stat_d = 1'b1;
					state_d    = S_FINISH;
				end else if (!active_q[v_idx]) begin
					state_d = S_G1;
				end else begin
					v_d = v_q + VC'(1);
				end
			end
			// user gain update, read-modify-write
			S_SET: begin
				if (sel_ok) begin
					vr_re    = 1'b1;
					vr_raddr = sel_idx;
					state_d  = S_SET_W;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SET_W: begin
				vr_we         = 1'b1;
				vr_waddr      = sel_idx;
				vr_wdata      = vr_rdata;
				vr_wdata.user = item_q.user_gain;
				state_d       = S_FINISH;
			end
			// voice loop of a mix
			S_MIX_VOICE: begin
				if (v_done) begin
					res_l_d = sat16(acc_l_q);
					res_r_d = sat16(acc_r_q);
					frame_d = (frame_q == FW'(FRAMES - 1)) ? '0 : frame_q + FW'(1);
					state_d = S_FINISH;
				end else if (active_q[v_idx]) begin
					vr_re   = 1'b1;
					state_d = S_MIX_LOAD;
				end else begin
					v_d = v_q + VC'(1);
				end
			end
			S_MIX_LOAD: begin
				rec_d   = vr_rdata;
				state_d = (frame_q == '0) ? S_G1 : S_CUR;
			end
			// gain = tweak * min(user, unity) * master
			S_G1: begin
				mul_start = 1'b1;
				mul_mc    = $signed({16'b0, tweak_src});
				mul_mp    = {2'b0, user_min};
				state_d   = S_G1_W;
			end
			S_G1_W: begin
				if (mul_stat.done) begin
					g_d     = {2'b0, mul_prod[29:14]};
					state_d = S_G2;
				end
			end
			S_G2: begin
				mul_start = 1'b1;
				mul_mc    = $signed({16'b0, g_q[15:0]});
				mul_mp    = {2'b0, master_q};
				state_d   = S_G2_W;
			end
			S_G2_W: begin
				if (mul_stat.done) begin
					g_d     = mul_prod[31:14];
					state_d = (cmd_q == CMD_START) ? S_START_WR : S_RAMP;
				end
			end
			S_START_WR: begin
				vr_we           = 1'b1;
				vr_wdata.loops  = item_q.loop_flag;
				vr_wdata.base   = item_q.sound_base;
				vr_wdata.len    = item_q.sound_length;
				vr_wdata.pos    = '0;
				vr_wdata.tweak  = item_q.tweak_gain;
				vr_wdata.user   = UNITY_GAIN;
				vr_wdata.prev   = g_q;
				vr_wdata.origin = g_q;
				vr_wdata.slope  = '0;
				active_d[v_idx] = 1'b1;
				res_vidx_d      = v_wide[4:0];
				state_d         = S_FINISH;
			end
			// ramp setup at a buffer start
			S_RAMP: begin
				if (g_q != rec_q.prev) begin
					div_start = 1'b1;
					div_num   = {1'b0, gmag[17:0], 12'b0};
					div_den   = DIV_DEN_W'(BUFFER_SAMPLES);
					state_d   = S_RAMP_W;
				end else begin
					rec_d.origin = g_q;
					rec_d.slope  = '0;
					rec_d.prev   = g_q;
					state_d      = S_CUR;
				end
			end
			S_RAMP_W: begin
				if (div_stat.done) begin
					rec_d.origin = rec_q.prev;
					rec_d.slope  = gdiff[18] ? -quot_s : quot_s;
					rec_d.prev   = g_q;
					state_d      = S_CUR;
				end
			end
			// current gain on the ramp
			S_CUR: begin
				mul_start = 1'b1;
				mul_mc    = rec_q.slope;
				mul_mp    = j_wide[17:0];
				state_d   = S_CUR_W;
			end
			S_CUR_W: begin
				if (mul_stat.done) begin
					cur_d   = ramp_t[50] ? 18'd0 : ramp_t[29:12];
					k_d     = 1'b0;
					state_d = S_ADDR;
				end
			end
			// left then right word of the voice
			S_ADDR: begin
				if (silent) begin
					if (!k_q) begin
						k_d = 1'b1;
					end else begin
						state_d = S_VOICE_WR;
					end
				end else if (SW_POW2) begin
					addr_d  = sum_wide[AW-1:0];
					state_d = S_RD;
				end else begin
					div_start = 1'b1;
					div_num   = {13'b0, sum_addr};
					div_den   = DIV_DEN_W'(SAMPLE_WORDS);
					state_d   = S_ADDR_W;
				end
			end
			S_ADDR_W: begin
				if (div_stat.done) begin
					addr_d  = div_rem[AW-1:0];
					state_d = S_RD;
				end
			end
			S_RD: begin
				samp_re = 1'b1;
				state_d = S_RD_W;
			end
			S_RD_W: begin
				mul_start = 1'b1;
				mul_mc    = $signed({{16{samp_rdata[15]}}, samp_rdata});
				mul_mp    = cur_q;
				state_d   = S_WMUL_W;
			end
			S_WMUL_W: begin
				if (mul_stat.done) begin
					if (!k_q) begin
						acc_l_d = acc_l_q + contrib;
						k_d     = 1'b1;
						state_d = S_ADDR;
					end else begin
						acc_r_d = acc_r_q + contrib;
						state_d = S_VOICE_WR;
					end
				end
			end
			S_VOICE_WR: begin
				vr_we = 1'b1;
				if (wrap && !rec_q.loops) begin
					active_d[v_idx] = 1'b0;
				end
				v_d     = v_q + VC'(1);
				state_d = S_MIX_VOICE;
			end
			S_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {3'b0, res_vidx_q, res_r_q, res_l_q};
			out_user_q <= res_stat_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_user_q;

	// master gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= UNITY_GAIN;
		end else if (cfg_valid) begin
			master_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// shared arithmetic units
	mvsm_serial_mul #(
		.MC_W (MUL_MC_W),
		.MP_W (MUL_MP_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mc),
		.mplier  (mul_mp),
		.stat    (mul_stat),
		.product (mul_prod)
	);

	mvsm_serial_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (DIV_DEN_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.num       (div_num),
		.den       (div_den),
		.stat      (div_stat),
		.quot      (div_quot),
		.remainder (div_rem)
	);

	// sample memory
	mvsm_ram #(
		.WIDTH (16),
		.DEPTH (SAMPLE_WORDS)
	) u_samples (
		.clk   (clk),
		.we    (samp_we),
		.waddr (samp_waddr),
		.wdata (item_q.sample_data),
		.re    (samp_re),
		.raddr (samp_raddr),
		.rdata (samp_rdata)
	);

	// voice record memory
	mvsm_ram #(
		.WIDTH ($bits(mvsm_voice_t)),
		.DEPTH (NUM_VOICES)
	) u_voices (
		.clk   (clk),
		.we    (vr_we),
		.waddr (vr_waddr),
		.wdata (vr_wdata),
		.re    (vr_re),
		.raddr (vr_raddr),
		.rdata (vr_rdata)
	);

	// serial units are only started when idle
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy) else $error("multiplier started while busy");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy) else $error("divider started while busy");

	// a failed start means every voice was playing
	a_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && v_done) |-> (&active_q))
		else $error("start refused with a free voice");

	// a finished command always lands in the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && (!out_valid_q || m_tready)) |=> out_valid_q)
		else $error("result lost at finish");

	// an accepted word always starts the sequencer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE)) else $error("accepted word dropped");

endmodule

// ===== rtl/mvsm_ram.sv =====
// generic single-write, single-read memory with registered read data
// no dependencies
module mvsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

// ===== rtl/mvsm_serial_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle
// signed multiplicand times unsigned multiplier; uses mvsm_pkg
module mvsm_serial_mul import mvsm_pkg::*; #(
	parameter int MC_W = 32,
	parameter int MP_W = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [MC_W-1:0]        mcand,
	input  logic [MP_W-1:0]               mplier,
	output mvsm_unit_stat_t               stat,
	output logic signed [MC_W+MP_W-1:0]   product
);

	localparam int CW = (MP_W > 1) ? $clog2(MP_W) : 1;

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic signed [MC_W-1:0] mc_q;
	logic signed [MC_W:0]   hi_q;
	logic [MP_W-1:0]        lo_q;
	logic signed [MC_W:0]   add_v;
	logic signed [MC_W:0]   sum_v;
	logic signed [MC_W:0]   sum_sh;

	// partial product step
	assign add_v  = lo_q[0] ? {mc_q[MC_W-1], mc_q} : '0;
	assign sum_v  = hi_q + add_v;
	assign sum_sh = sum_v >>> 1;

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(MP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// product shift register
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			mc_q <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (busy_q) begin
			hi_q <= sum_sh;
			lo_q <= {sum_v[0], lo_q[MP_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = {hi_q[MC_W-1:0], lo_q};

endmodule

// ===== rtl/mvsm_serial_div.sv =====
// restoring divider, one quotient bit per cycle
// gives quotient and remainder of unsigned operands; uses mvsm_pkg
module mvsm_serial_div import mvsm_pkg::*; #(
	parameter int NUM_W = 31,
	parameter int DEN_W = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [DEN_W-1:0]   den,
	output mvsm_unit_stat_t    stat,
	output logic [NUM_W-1:0]   quot,
	output logic [DEN_W-1:0]   remainder
);

	localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W:0]     trial;
	logic [DEN_W:0]     diff;
	logic               ge;

	// trial subtract of the next partial remainder
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = num_q;
	assign remainder = rem_q;

endmodule
